// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the lenient UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 22;
  localparam int unsigned USED_W  = 3;
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned OUT_W   = 32;

  localparam logic [CP_W-1:0]   REPL_CHAR  = 22'h00FFFD;
  localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MIN   = 8'h80;

  // One-hot sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FOLD = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/utf8_lenient_decoder.sv =====
// A byte is accepted only while the sequencer is idle, so a new request waits
// until the queued bytes are resolved or wait for more followers; the shared
// fold unit takes one follower per cycle. Bytes left behind by a failed lead
// are scanned again, and a stalled output holds the sequencer.
// Reset (rst, synchronous, active high) empties the queue and drops any result.
// ----------------------------------------------------------------------------
// utf8_lenient_decoder
// Lenient UTF-8 decoder: takes one byte per request and emits code points,
// replacing malformed sequences with U+FFFD one lead byte at a time.
// ----------------------------------------------------------------------------
module utf8_lenient_decoder
  import utf8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Input stream.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] data_byte
  input  logic             s_tlast,   // string_end
  // Output stream.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // [21:0] code_point, [24:22] bytes_used, rest zero
  output logic             m_tlast    // last_of_string
);

  // The byte queue holds the bytes of an unfinished sequence, lead first at
  // entry 0. It is only ever read at fixed positions; consuming a byte shifts
  // the whole queue down by one.
  logic [BYTE_W-1:0] q [QDEPTH];
  logic [CNT_W-1:0]  cnt;
  logic              at_end;

  state_t            state;

  // Fold unit: shifts the sum six bits left and adds the low seven bits of each follower byte.
  logic [CP_W-1:0]   acc;
  logic [1:0]        rem;
  logic [USED_W-1:0] seq_used;

  // Output register.
  logic              out_valid;
  logic [CP_W-1:0]   out_cp;
  logic [USED_W-1:0] out_used;
  logic              out_last;
  logic              out_load;

  logic              in_fire;
  logic              out_free;

  // Lead decode for the byte at the head of the queue.
  logic [BYTE_W-1:0] lead;
  logic [1:0]        need;
  logic [CP_W-1:0]   lead_bits;
  logic              follow_bad;
  logic              short_seq;
  logic              single_res;
  logic [CNT_W-1:0]  cnt_less1;

  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign lead      = q[0];
  assign cnt_less1 = cnt - CNT_W'(1);

  always_comb begin
    if (lead >= LEAD4_MIN) begin
      need      = 2'd3;
      lead_bits = CP_W'(lead[3:0]);
    end else if (lead >= LEAD3_MIN) begin
      need      = 2'd2;
      lead_bits = CP_W'(lead[3:0]);
    end else begin
      need      = 2'd1;
      lead_bits = CP_W'(lead[4:0]);
    end
  end

  // A follower that is present and due but below 0x80 breaks the sequence.
  always_comb begin
    follow_bad = 1'b0;
    for (int k = 1; k < QDEPTH; k++) begin
      if ((k <= int'(need)) && (k < int'(cnt)) && (q[k] < CONT_MIN)) begin
        follow_bad = 1'b1;
      end
    end
  end

  assign short_seq = (cnt_less1 < CNT_W'(need));

  // The head byte resolves on its own: ASCII, lone continuation or a failed lead.
  assign single_res = (lead < LEAD2_MIN) || follow_bad || (short_seq && at_end);

  // A result enters the output register in this cycle.
  assign out_load = out_free &&
                    (((state == ST_SCAN) && (cnt != '0) && single_res) ||
                     ((state == ST_FOLD) && (rem == '0)));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      at_end    <= 1'b0;
      rem       <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            q[cnt[1:0]] <= s_tdata;
            cnt         <= cnt + CNT_W'(1);
            at_end      <= s_tlast;
            state       <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (cnt == '0) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            if (single_res) begin
              // Single-byte result: ASCII, lone continuation or a failed lead.
              out_cp    <= (lead < CONT_MIN) ? CP_W'(lead) : REPL_CHAR;
              out_used  <= USED_W'(1);
              out_last  <= at_end && (cnt_less1 == '0);
              for (int i = 0; i < QDEPTH - 1; i++) q[i] <= q[i+1];
              cnt <= cnt_less1;
              if (cnt_less1 == '0) state <= ST_IDLE;
            end else if (short_seq) begin
              // Sequence still waiting for followers: hold the bytes.
              state <= ST_IDLE;
            end else begin
              acc      <= lead_bits;
              rem      <= need;
              seq_used <= USED_W'(need) + USED_W'(1);
              for (int i = 0; i < QDEPTH - 1; i++) q[i] <= q[i+1];
              cnt   <= cnt_less1;
              state <= ST_FOLD;
            end
          end
        end

        ST_FOLD: begin
          if (rem != '0) begin
            acc <= {acc[CP_W-7:0], 6'b0} + CP_W'(q[0][6:0]);
            rem <= rem - 2'd1;
            for (int i = 0; i < QDEPTH - 1; i++) q[i] <= q[i+1];
            cnt <= cnt_less1;
          end else if (out_free) begin
            out_cp    <= acc;
            out_used  <= seq_used;
            out_last  <= at_end && (cnt == '0);
            state     <= (cnt == '0) ? ST_IDLE : ST_SCAN;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // The output register fills when the sequencer hands over a result and
  // empties when the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W - CP_W - USED_W){1'b0}}, out_used, out_cp};
  assign m_tlast  = out_last;

  // At most three bytes of an unfinished sequence wait between requests.
  a_idle_depth: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt <= CNT_W'(3)))
    else $error("queue holds more than three bytes while idle");

  // After the end of a string every byte has been resolved.
  a_end_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && at_end) |-> (cnt == '0))
    else $error("bytes left over after end of string");

  // The fold unit never runs out of follower bytes.
  a_fold_bytes: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD) |-> (CNT_W'(rem) <= cnt))
    else $error("fold step without a follower byte");

  // Every result consumed between one and four bytes.
  a_used_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_used != '0 && out_used <= USED_W'(4)))
    else $error("bytes_used out of range");

endmodule
